/* rtl/ccr_pkg.sv */
// Shared constants and table generator for the contrast ratio pipeline.
package ccr_pkg;

  localparam int unsigned CodeW     = 8;
  localparam int unsigned LutDepth  = 256;
  localparam int unsigned LinMaxW   = 25;

  localparam int unsigned WeightRed   = 2126;
  localparam int unsigned WeightGreen = 7152;
  localparam int unsigned WeightBlue  = 722;
  localparam int unsigned WeightRound = 5000;
  localparam int unsigned WeightShift = 4;
  localparam int unsigned WeightOdd   = 625;

  localparam int unsigned RatioW        = 13;
  localparam int unsigned RatioFracBits = 8;
  localparam int unsigned OffsetScale   = 20;

  localparam int unsigned LinCodeKnee  = 10;
  localparam int unsigned LinCodeFull  = 255;

  function automatic logic [LinMaxW-1:0] lin_entry(input int unsigned code,
                                                   input int unsigned frac);
    longint unsigned cl;
    longint unsigned one;
    longint unsigned n;
    longint unsigned t;
    longint unsigned s;
    longint unsigned y;
    longint unsigned cand;
    longint unsigned r;
    longint unsigned p;
    cl  = 64'(code);
    one = 64'd1 << frac;
    if (cl <= LinCodeKnee) begin
      return LinMaxW'((cl * one * 64'd20 + 64'd32946) / 64'd65892);
    end
    if (cl == LinCodeFull) begin
      return LinMaxW'(one);
    end
    n = 64'd1000 * cl + 64'd14025;
    t = (n << 32) / 64'd269025;
    s = (t * t) >> 32;
    y = 64'd0;
    for (int b = 31; b >= 0; b--) begin
      cand = y | (64'd1 << b);
      r = (cand * cand) >> 32;
      r = (r * cand) >> 32;
      r = (r * cand) >> 32;
      r = (r * cand) >> 32;
      if (r <= s) begin
        y = cand;
      end
    end
    p = (s * y) >> 32;
    return LinMaxW'((p + (64'd1 << (31 - frac))) >> (32 - frac));
  endfunction

endpackage

/* rtl/ccr_lin_rom.sv */
// Registered sRGB linearization table lookup for one channel.
module ccr_lin_rom #(
  parameter int unsigned LUMA_FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic [ccr_pkg::CodeW-1:0]           code_i,
  output logic [LUMA_FRAC_BITS:0]             lin_o
);

  logic [LUMA_FRAC_BITS:0] rom [ccr_pkg::LutDepth];
  logic [LUMA_FRAC_BITS:0] lin_q;

  for (genvar c = 0; c < ccr_pkg::LutDepth; c++) begin : g_rom
    localparam logic [ccr_pkg::LinMaxW-1:0] Entry =
      ccr_pkg::lin_entry(c, LUMA_FRAC_BITS);
    assign rom[c] = Entry[LUMA_FRAC_BITS:0];
  end

  always_ff @(posedge clk_i) begin
    lin_q <= rom[code_i];
  end

  assign lin_o = lin_q;

endmodule

/* rtl/ccr_luma.sv */
// Relative luminance of one colour: table lookup, weighted sum, divide by 10000.
module ccr_luma #(
  parameter int unsigned LUMA_FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [ccr_pkg::CodeW-1:0]   red_i,
  input  logic [ccr_pkg::CodeW-1:0]   green_i,
  input  logic [ccr_pkg::CodeW-1:0]   blue_i,
  output logic                        valid_o,
  output logic [LUMA_FRAC_BITS:0]     luma_o
);

  localparam int unsigned LumaW = LUMA_FRAC_BITS + 1;
  localparam int unsigned SumW  = LUMA_FRAC_BITS + 14;
  localparam int unsigned XW    = SumW - ccr_pkg::WeightShift;
  localparam int unsigned ProdW = XW + LumaW;
  localparam longint unsigned RecipFull = (64'd1 << XW) / ccr_pkg::WeightOdd;
  localparam logic [LumaW-1:0] Recip = LumaW'(RecipFull);

  logic [3:0]       vld_q;
  logic [LumaW-1:0] lin_r;
  logic [LumaW-1:0] lin_g;
  logic [LumaW-1:0] lin_b;
  logic [SumW-1:0]  sum_d;
  logic [SumW-1:0]  sum_q;
  logic [XW-1:0]    xs;
  logic [ProdW-1:0] prod;
  logic [LumaW-1:0] quo_d;
  logic [LumaW-1:0] quo_q;
  logic [XW-1:0]    xs_q;
  logic [XW-1:0]    rem;
  logic [LumaW-1:0] luma_d;
  logic [LumaW-1:0] luma_q;

  ccr_lin_rom #(.LUMA_FRAC_BITS(LUMA_FRAC_BITS)) u_rom_r (
    .clk_i (clk_i),
    .code_i(red_i),
    .lin_o (lin_r)
  );

  ccr_lin_rom #(.LUMA_FRAC_BITS(LUMA_FRAC_BITS)) u_rom_g (
    .clk_i (clk_i),
    .code_i(green_i),
    .lin_o (lin_g)
  );

  ccr_lin_rom #(.LUMA_FRAC_BITS(LUMA_FRAC_BITS)) u_rom_b (
    .clk_i (clk_i),
    .code_i(blue_i),
    .lin_o (lin_b)
  );

  assign sum_d = SumW'(lin_r) * SumW'(ccr_pkg::WeightRed)
               + SumW'(lin_g) * SumW'(ccr_pkg::WeightGreen)
               + SumW'(lin_b) * SumW'(ccr_pkg::WeightBlue)
               + SumW'(ccr_pkg::WeightRound);

  assign xs    = XW'(sum_q >> ccr_pkg::WeightShift);
  assign prod  = ProdW'(xs) * ProdW'(Recip);
  assign quo_d = prod[XW +: LumaW];

  assign rem    = xs_q - XW'(XW'(quo_q) * XW'(ccr_pkg::WeightOdd));
  assign luma_d = (rem >= XW'(ccr_pkg::WeightOdd)) ? quo_q + LumaW'(1) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    quo_q  <= quo_d;
    xs_q   <= xs;
    luma_q <= luma_d;
  end

  assign valid_o = vld_q[3];
  assign luma_o  = luma_q;

endmodule

/* rtl/ccr_ratio.sv */
// Contrast ratio: order the luminances, then a bit-per-stage restoring divider.
module ccr_ratio #(
  parameter int unsigned LUMA_FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [LUMA_FRAC_BITS:0]          luma_a_i,
  input  logic [LUMA_FRAC_BITS:0]          luma_b_i,
  output logic                             valid_o,
  output logic [ccr_pkg::RatioW-1:0]       ratio_o,
  output logic [LUMA_FRAC_BITS:0]          luma_a_o,
  output logic [LUMA_FRAC_BITS:0]          luma_b_o
);

  localparam int unsigned LumaW  = LUMA_FRAC_BITS + 1;
  localparam int unsigned DenW   = LUMA_FRAC_BITS + 5;
  localparam int unsigned NumW   = DenW + ccr_pkg::RatioFracBits;
  localparam int unsigned Steps  = ccr_pkg::RatioW;
  localparam int unsigned CmpW   = DenW + Steps;

  logic             vld_q  [Steps+1];
  logic [NumW-1:0]  rem_q  [Steps+1];
  logic [DenW-1:0]  den_q  [Steps+1];
  logic [Steps-1:0] quo_q  [Steps+1];
  logic [LumaW-1:0] la_q   [Steps+1];
  logic [LumaW-1:0] lb_q   [Steps+1];

  logic [LumaW-1:0] hi;
  logic [LumaW-1:0] lo;
  logic [DenW-1:0]  num_base;
  logic [DenW-1:0]  den_d;

  assign hi = (luma_a_i > luma_b_i) ? luma_a_i : luma_b_i;
  assign lo = (luma_a_i > luma_b_i) ? luma_b_i : luma_a_i;

  assign num_base = DenW'(hi) * DenW'(ccr_pkg::OffsetScale)
                  + (DenW'(1) << LUMA_FRAC_BITS);
  assign den_d    = DenW'(lo) * DenW'(ccr_pkg::OffsetScale)
                  + (DenW'(1) << LUMA_FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= {num_base, ccr_pkg::RatioFracBits'(0)};
    den_q[0] <= den_d;
    quo_q[0] <= '0;
    la_q[0]  <= luma_a_i;
    lb_q[0]  <= luma_b_i;
  end

  for (genvar k = 0; k < Steps; k++) begin : g_div
    localparam int unsigned Bit = Steps - 1 - k;
    logic [CmpW-1:0] shifted;
    logic [CmpW-1:0] rem_ext;
    logic            take;

    assign shifted = CmpW'(den_q[k]) << Bit;
    assign rem_ext = CmpW'(rem_q[k]);
    assign take    = rem_ext >= shifted;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= take ? NumW'(rem_ext - shifted) : rem_q[k];
      den_q[k+1] <= den_q[k];
      quo_q[k+1] <= {quo_q[k][Steps-2:0], take};
      la_q[k+1]  <= la_q[k];
      lb_q[k+1]  <= lb_q[k];
    end
  end

  assign valid_o  = vld_q[Steps];
  assign ratio_o  = quo_q[Steps];
  assign luma_a_o = la_q[Steps];
  assign luma_b_o = lb_q[Steps];

endmodule

/* rtl/colour_contrast_ratio.sv */
// Top level: contrast ratio and relative luminances of two sRGB colours.
//
// Command channel: a colour pair is taken at each rising edge with start_i
// high and busy_o low. busy_o never rises, so a new pair may enter in every
// cycle and one pair per pipeline register can be in flight at once.
// Result channel: done_o is high for one cycle with contrast_ratio_o
// (Q5.8), first_luminance_o and second_luminance_o (Q1.F); the receiver
// takes every result in that cycle and cannot hold it off.
// Pipeline: table lookup, weighted sum, divide by 10000 (multiply by a
// reciprocal, then correct), a register that orders the luminances and
// 13 divider stages, one quotient bit each.
// Throughput: one pair per cycle, set by the fully pipelined divider.
// Reset clears all valid bits; pairs in flight are dropped and no
// result appears until a new pair has traveled the pipeline.
module colour_contrast_ratio #(
  parameter int unsigned LUMA_FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [ccr_pkg::CodeW-1:0]         first_red_i,
  input  logic [ccr_pkg::CodeW-1:0]         first_green_i,
  input  logic [ccr_pkg::CodeW-1:0]         first_blue_i,
  input  logic [ccr_pkg::CodeW-1:0]         second_red_i,
  input  logic [ccr_pkg::CodeW-1:0]         second_green_i,
  input  logic [ccr_pkg::CodeW-1:0]         second_blue_i,
  output logic                              done_o,
  output logic [ccr_pkg::RatioW-1:0]        contrast_ratio_o,
  output logic [LUMA_FRAC_BITS:0]           first_luminance_o,
  output logic [LUMA_FRAC_BITS:0]           second_luminance_o
);

  logic                    accept;
  logic                    va;
  logic                    vb;
  logic [LUMA_FRAC_BITS:0] luma_a;
  logic [LUMA_FRAC_BITS:0] luma_b;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  ccr_luma #(.LUMA_FRAC_BITS(LUMA_FRAC_BITS)) u_luma_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(accept),
    .red_i  (first_red_i),
    .green_i(first_green_i),
    .blue_i (first_blue_i),
    .valid_o(va),
    .luma_o (luma_a)
  );

  ccr_luma #(.LUMA_FRAC_BITS(LUMA_FRAC_BITS)) u_luma_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(accept),
    .red_i  (second_red_i),
    .green_i(second_green_i),
    .blue_i (second_blue_i),
    .valid_o(vb),
    .luma_o (luma_b)
  );

  ccr_ratio #(.LUMA_FRAC_BITS(LUMA_FRAC_BITS)) u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (va & vb),
    .luma_a_i(luma_a),
    .luma_b_i(luma_b),
    .valid_o (done_o),
    .ratio_o (contrast_ratio_o),
    .luma_a_o(first_luminance_o),
    .luma_b_o(second_luminance_o)
  );

endmodule

/* test/colour_contrast_ratio_tb.sv */
// Self-checking bench for the contrast ratio pipeline with a per-beat result predictor.
`timescale 1ns / 1ps

module colour_contrast_ratio_tb;

  localparam int unsigned LumaFrac   = 16;
  localparam int unsigned CodeW      = ccr_pkg::CodeW;
  localparam int unsigned RatioW     = ccr_pkg::RatioW;
  localparam int unsigned CodeMax    = 255;
  localparam int unsigned KneeCode   = 10;
  localparam int unsigned RedWeight  = 2126;
  localparam int unsigned GrnWeight  = 7152;
  localparam int unsigned BluWeight  = 722;
  localparam int unsigned WeightSum  = 10000;
  localparam int unsigned DrainTail  = 24;
  localparam int unsigned ReportMax  = 10;

  typedef struct packed {
    logic [CodeW-1:0] r0;
    logic [CodeW-1:0] g0;
    logic [CodeW-1:0] b0;
    logic [CodeW-1:0] r1;
    logic [CodeW-1:0] g1;
    logic [CodeW-1:0] b1;
  } colour_pair_t;

  typedef struct packed {
    logic [RatioW-1:0]   ratio;
    logic [LumaFrac:0]   luma_first;
    logic [LumaFrac:0]   luma_second;
  } contrast_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [CodeW-1:0]    first_red_i;
  logic [CodeW-1:0]    first_green_i;
  logic [CodeW-1:0]    first_blue_i;
  logic [CodeW-1:0]    second_red_i;
  logic [CodeW-1:0]    second_green_i;
  logic [CodeW-1:0]    second_blue_i;
  logic                done_o;
  logic [RatioW-1:0]   contrast_ratio_o;
  logic [LumaFrac:0]   first_luminance_o;
  logic [LumaFrac:0]   second_luminance_o;

  logic [LumaFrac:0]   linear_code [0:CodeMax];
  contrast_t           pending_contrast [$];
  int unsigned         fail_count;
  bit                  idle_on;

  colour_contrast_ratio #(
    .LUMA_FRAC_BITS(LumaFrac)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .first_red_i       (first_red_i),
    .first_green_i     (first_green_i),
    .first_blue_i      (first_blue_i),
    .second_red_i      (second_red_i),
    .second_green_i    (second_green_i),
    .second_blue_i     (second_blue_i),
    .done_o            (done_o),
    .contrast_ratio_o  (contrast_ratio_o),
    .first_luminance_o (first_luminance_o),
    .second_luminance_o(second_luminance_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #1 clk_i = ~clk_i;
  end

  function automatic logic [LumaFrac:0] linearize_code(input int unsigned code);
    longint unsigned one_q;
    longint unsigned base;
    longint unsigned sq;
    longint unsigned root;
    longint unsigned trial;
    longint unsigned pw;
    longint unsigned prod;
    one_q = 64'd1 << LumaFrac;
    if (code <= KneeCode) begin
      return (LumaFrac+1)'((64'(code) * one_q * 64'd20 + 64'd32946) / 64'd65892);
    end
    if (code == CodeMax) begin
      return (LumaFrac+1)'(one_q);
    end
    base = ((64'd1000 * 64'(code) + 64'd14025) << 32) / 64'd269025;
    sq   = (base * base) >> 32;
    root = 64'd0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      pw = (trial * trial) >> 32;
      pw = (pw * trial) >> 32;
      pw = (pw * trial) >> 32;
      pw = (pw * trial) >> 32;
      if (pw <= sq) begin
        root = trial;
      end
    end
    prod = (sq * root) >> 32;
    return (LumaFrac+1)'((prod + (64'd1 << (31 - LumaFrac))) >> (32 - LumaFrac));
  endfunction

  function automatic logic [LumaFrac:0] relative_luma(input logic [CodeW-1:0] r,
                                                      input logic [CodeW-1:0] g,
                                                      input logic [CodeW-1:0] b);
    longint unsigned sum;
    sum = 64'(RedWeight) * 64'(linear_code[r]) + 64'(GrnWeight) * 64'(linear_code[g])
        + 64'(BluWeight) * 64'(linear_code[b]);
    return (LumaFrac+1)'((sum + 64'(WeightSum / 2)) / 64'(WeightSum));
  endfunction

  function automatic contrast_t predict_contrast(input colour_pair_t pair);
    contrast_t       res;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned one_q;
    one_q = 64'd1 << LumaFrac;
    res.luma_first  = relative_luma(pair.r0, pair.g0, pair.b0);
    res.luma_second = relative_luma(pair.r1, pair.g1, pair.b1);
    hi = 64'((res.luma_first > res.luma_second) ? res.luma_first : res.luma_second);
    lo = 64'((res.luma_first > res.luma_second) ? res.luma_second : res.luma_first);
    res.ratio = RatioW'((64'd256 * (64'd20 * hi + one_q)) / (64'd20 * lo + one_q));
    return res;
  endfunction

  // Result checker: the receiver takes every beat, so compare on each done_o.
  always @(posedge clk_i) begin
    contrast_t want;
    if (rst_ni && done_o) begin
      if (pending_contrast.size() == 0) begin
        fail_count++;
        if (fail_count <= ReportMax) begin
          $display("unexpected result: ratio %0d lum %0d/%0d", contrast_ratio_o,
                   first_luminance_o, second_luminance_o);
        end
      end else begin
        want = pending_contrast.pop_front();
        if (contrast_ratio_o !== want.ratio || first_luminance_o !== want.luma_first ||
            second_luminance_o !== want.luma_second) begin
          fail_count++;
          if (fail_count <= ReportMax) begin
            $display("mismatch exp/got: ratio %0d/%0d lum1 %0d/%0d lum2 %0d/%0d",
                     want.ratio, contrast_ratio_o, want.luma_first, first_luminance_o,
                     want.luma_second, second_luminance_o);
          end
        end
      end
    end
  end

  task automatic send_pair(input colour_pair_t pair);
    while (idle_on && $urandom_range(99) < 13) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    first_red_i    <= pair.r0;
    first_green_i  <= pair.g0;
    first_blue_i   <= pair.b0;
    second_red_i   <= pair.r1;
    second_green_i <= pair.g1;
    second_blue_i  <= pair.b1;
    @(posedge clk_i);
    while (busy_o) begin
      @(posedge clk_i);
    end
    pending_contrast.push_back(predict_contrast(pair));
  endtask

  task automatic send_colours(input int unsigned r0, input int unsigned g0,
                              input int unsigned b0, input int unsigned r1,
                              input int unsigned g1, input int unsigned b1);
    colour_pair_t pair;
    pair = '{CodeW'(r0), CodeW'(g0), CodeW'(b0), CodeW'(r1), CodeW'(g1), CodeW'(b1)};
    send_pair(pair);
  endtask

  // Hold off the sender until every outstanding result has arrived.
  task automatic wait_for_results();
    start_i <= 1'b0;
    while (pending_contrast.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic test_directed();
    send_colours(0, 0, 0, 255, 255, 255);
    send_colours(255, 255, 255, 0, 0, 0);
    send_colours(255, 255, 255, 255, 255, 255);
    send_colours(0, 0, 0, 0, 0, 0);
    send_colours(128, 128, 128, 128, 128, 128);
    send_colours(255, 0, 0, 0, 0, 0);
    send_colours(0, 255, 0, 0, 0, 0);
    send_colours(0, 0, 255, 0, 0, 0);
    send_colours(10, 10, 10, 11, 11, 11);
    send_colours(11, 11, 11, 10, 10, 10);
    send_colours(1, 1, 1, 0, 0, 0);
    send_colours(254, 254, 254, 255, 255, 255);
    send_colours(255, 255, 0, 0, 0, 255);
    send_colours(0, 255, 255, 255, 0, 0);
    send_colours(255, 0, 255, 0, 255, 0);
    send_colours(10, 11, 255, 255, 10, 11);
    send_colours(128, 128, 128, 127, 127, 127);
    send_colours(255, 255, 255, 254, 254, 254);
    send_colours(0, 0, 1, 255, 255, 254);
    send_colours(5, 200, 77, 5, 200, 77);
    wait_for_results();
  endtask

  // Walk every code through every channel.
  task automatic test_code_sweep();
    for (int unsigned c = 0; c <= CodeMax; c++) begin
      send_colours((c + 0) % 256, (c + 85) % 256, (c + 170) % 256,
                   (c + 43) % 256, (c + 128) % 256, (c + 213) % 256);
    end
    wait_for_results();
  endtask

  task automatic test_random(input int unsigned count);
    colour_pair_t pair;
    int unsigned  kind;
    for (int unsigned i = 0; i < count; i++) begin
      idle_on = !(i >= 300 && i < 650);
      if (i == 800) begin
        wait_for_results();
      end
      pair = colour_pair_t'({$urandom, $urandom});
      kind = $urandom_range(9);
      if (kind == 0) begin
        {pair.r1, pair.g1, pair.b1} = {pair.r0, pair.g0, pair.b0};
      end else if (kind == 1) begin
        {pair.g0, pair.b0} = {pair.r0, pair.r0};
        {pair.g1, pair.b1} = {pair.r1, pair.r1};
      end else if (kind == 2) begin
        pair.r0 = CodeW'($urandom_range(1) ? CodeMax : 0);
        pair.g1 = CodeW'($urandom_range(1) ? CodeMax : 0);
        pair.b0 = CodeW'($urandom_range(KneeCode + 1));
      end
      send_pair(pair);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_ni         <= 1'b0;
    start_i        <= 1'b0;
    first_red_i    <= '0;
    first_green_i  <= '0;
    first_blue_i   <= '0;
    second_red_i   <= '0;
    second_green_i <= '0;
    second_blue_i  <= '0;
    fail_count     = 0;
    idle_on        = 1'b1;
    for (int unsigned c = 0; c <= CodeMax; c++) begin
      linear_code[CodeW'(c)] = linearize_code(c);
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_code_sweep();
    test_random(1174);
    wait_for_results();
    repeat (DrainTail) @(posedge clk_i);
    if (fail_count == 0 && pending_contrast.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/ccr_pkg.sv
rtl/ccr_lin_rom.sv
rtl/ccr_luma.sv
rtl/ccr_ratio.sv
rtl/colour_contrast_ratio.sv
test/colour_contrast_ratio_tb.sv
